### rtl/pfc_pkg.sv
package pfc_pkg;

  // Color table geometry
  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned FMT_W       = 3;

  // Item actions
  localparam logic ACT_CONVERT   = 1'b0;
  localparam logic ACT_PAL_WRITE = 1'b1;

  // Source format codes
  localparam logic [FMT_W-1:0] FMT_PALETTE = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RGB555  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGB565  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_BYTES   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_SWAP32  = 3'd4;

  // Configuration register map
  localparam int unsigned      APB_AW            = 3;
  localparam logic             REG_SOURCE_FORMAT = 1'b0;

  // Request from the pipeline to the color table
  typedef struct packed {
    logic                 wr_en;
    logic                 rd_en;
    logic [INDEX_W-1:0]   index;
    logic [COLOR_W-1:0]   color;
  } pal_req_t;

endpackage

### rtl/pfc_pixel_if.sv
interface pfc_pixel_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [pfc_pkg::PIXEL_W-1:0]     pixel_in;
  logic [pfc_pkg::INDEX_W-1:0]     entry_index;
  logic [7:0]                      red_in;
  logic [7:0]                      green_in;
  logic [7:0]                      blue_in;

  modport source (
    output valid, action, pixel_in, entry_index, red_in, green_in, blue_in,
    input  ready
  );
  modport sink (
    input  valid, action, pixel_in, entry_index, red_in, green_in, blue_in,
    output ready
  );
endinterface

### rtl/pfc_color_if.sv
interface pfc_color_if;
  logic                            valid;
  logic                            ready;
  logic [pfc_pkg::COLOR_W-1:0]     color_out;

  modport source (
    output valid, color_out,
    input  ready
  );
  modport sink (
    input  valid, color_out,
    output ready
  );
endinterface

### rtl/pixel_format_to_rgb24_converter.sv
// Pixel format converter with a color table.
//
// The pixel channel carries one item per transfer. A convert item turns
// pixel_in into a packed color (red 7:0, green 15:8, blue 23:16) that leaves
// on the color channel; a table-write item stores red/green/blue at
// entry_index and produces no transfer on the color channel.
// source_format must be written over the APB port only while the block is idle
// (0 table index, 1 rgb555, 2 rgb565, 3 byte triple, 4 swapped 32-bit); the
// block itself does not enforce this.
// Throughput: one item per cycle while the receiver does not stall. A convert
// item's table read and pixel are registered in the read stage (stage 1), and
// its color is then registered in the output register. The table is a
// single-port-read synchronous RAM with one read per convert item.
//
// Reset clears source_format and marks every table entry as unwritten, so
// each entry reads as zero until it is written; no clearing pass is needed.
// When the receiver stalls, the output register and the read stage hold,
// and pixel.ready drops once both are full; nothing is lost or repeated.
module pixel_format_to_rgb24_converter (
  input  logic                          clk,
  input  logic                          rst,
  pfc_pixel_if.sink                     pixel,
  pfc_color_if.source                   color,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfc_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  logic [pfc_pkg::FMT_W-1:0]    source_format;
  logic                         cfg_write;

  logic                         accept;
  logic                         s1_valid;
  logic                         s1_valid_next;
  logic [23:0]                  s1_pixel;
  logic                         s1_adv;
  logic                         out_take;
  logic                         out_valid;
  logic [pfc_pkg::COLOR_W-1:0]  out_color;

  pfc_pkg::pal_req_t            pal_req;
  logic [pfc_pkg::COLOR_W-1:0]  pal_entry;
  logic [pfc_pkg::COLOR_W-1:0]  conv_color;

  // APB register: one word, write on the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == pfc_pkg::REG_SOURCE_FORMAT);
  assign prdata    = (paddr[2] == pfc_pkg::REG_SOURCE_FORMAT)
                     ? {29'b0, source_format} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= pfc_pkg::FMT_PALETTE;
    end else if (cfg_write) begin
      source_format <= pwdata[pfc_pkg::FMT_W-1:0];
    end
  end

  // Handshake: the output register frees up when empty or taken this cycle,
  // and the read stage advances into it; a new item enters behind.
  assign out_take    = !out_valid || color.ready;
  assign s1_adv      = s1_valid && out_take;
  assign pixel.ready = !s1_valid || out_take;
  assign accept      = pixel.valid && pixel.ready;

  // Table access issues at the accept edge; read data lands with stage 1.
  always_comb begin
    pal_req.wr_en = accept && (pixel.action == pfc_pkg::ACT_PAL_WRITE);
    pal_req.rd_en = accept && (pixel.action == pfc_pkg::ACT_CONVERT);
    pal_req.index = pal_req.wr_en ? pixel.entry_index
                                  : pixel.pixel_in[pfc_pkg::INDEX_W-1:0];
    pal_req.color = {pixel.blue_in, pixel.green_in, pixel.red_in};
  end

  pfc_palette u_palette (
    .clk   (clk),
    .rst   (rst),
    .req   (pal_req),
    .entry (pal_entry)
  );

  // Table writes produce no result, so only convert items occupy stage 1
  always_comb begin
    if (pal_req.rd_en) begin
      s1_valid_next = 1'b1;
    end else if (s1_adv) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_req.rd_en) begin
      s1_pixel <= pixel.pixel_in[23:0];
    end
  end

  pfc_unpack u_unpack (
    .fmt   (source_format),
    .pixel (s1_pixel),
    .entry (pal_entry),
    .color (conv_color)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_color <= conv_color;
    end
  end

  assign color.valid     = out_valid;
  assign color.color_out = out_color;
endmodule

### rtl/pfc_ram.sv
module pfc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/pfc_palette.sv
module pfc_palette (
  input  logic                          clk,
  input  logic                          rst,
  input  pfc_pkg::pal_req_t             req,
  output logic [pfc_pkg::COLOR_W-1:0]   entry
);
  logic                                   in_range;
  logic [pfc_pkg::PAL_AW-1:0]             addr;
  logic [pfc_pkg::PAL_ENTRIES-1:0]        written;
  logic                                   rd_live;
  logic [pfc_pkg::COLOR_W-1:0]            rdata;

  // Indexes past the table neither store nor read back
  assign in_range = ({1'b0, req.index} < (pfc_pkg::INDEX_W+1)'(pfc_pkg::PAL_ENTRIES));
  assign addr     = req.index[pfc_pkg::PAL_AW-1:0];

  pfc_ram #(
    .WIDTH (pfc_pkg::COLOR_W),
    .DEPTH (pfc_pkg::PAL_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en && in_range),
    .waddr (addr),
    .wdata (req.color),
    .re    (req.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  // Per-entry written flags stand in for clearing the table at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_live <= 1'b0;
    end else begin
      if (req.wr_en && in_range) begin
        written[addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_live <= in_range && written[addr];
      end
    end
  end

  assign entry = rd_live ? rdata : '0;
endmodule

### rtl/pfc_unpack.sv
module pfc_unpack (
  input  logic [pfc_pkg::FMT_W-1:0]     fmt,
  input  logic [23:0]                   pixel,
  input  logic [pfc_pkg::COLOR_W-1:0]   entry,
  output logic [pfc_pkg::COLOR_W-1:0]   color
);
  logic [4:0] r5;
  logic [4:0] g5;
  logic [5:0] g6;
  logic [4:0] b5_555;
  logic [4:0] b5_565;

  assign r5     = pixel[4:0];
  assign g5     = pixel[9:5];
  assign g6     = pixel[10:5];
  assign b5_555 = pixel[14:10];
  assign b5_565 = pixel[15:11];

  // Widen narrow channels by repeating their low bits
  always_comb begin
    unique case (fmt)
      pfc_pkg::FMT_PALETTE: color = entry;
      pfc_pkg::FMT_RGB555:  color = {b5_555, b5_555[2:0], g5, g5[2:0], r5, r5[2:0]};
      pfc_pkg::FMT_RGB565:  color = {b5_565, b5_565[2:0], g6, g6[1:0], r5, r5[2:0]};
      pfc_pkg::FMT_BYTES:   color = pixel;
      pfc_pkg::FMT_SWAP32:  color = {pixel[7:0], pixel[15:8], pixel[23:16]};
      default:              color = '0;
    endcase
  end
endmodule
